// ===== design/mlp_pkg.sv =====
// Shared constants, command bundle and helpers of the minimax linear partition unit.
`default_nettype none

package mlp_pkg;

  // Sizing of the leg store and the solver.
  localparam int MAX_LEGS   = 513;
  localparam int MAX_NIGHTS = 256;
  localparam int LEG_BITS   = 16;

  localparam int NIGHTS_W   = 9;
  localparam int CNT_W      = $clog2(MAX_LEGS + 1);
  localparam int IDX_W      = $clog2(MAX_LEGS);
  localparam int SUM_W      = LEG_BITS + $clog2(MAX_LEGS);
  localparam int COST_W     = SUM_W + 1;
  localparam int COST_DEPTH = 2 * MAX_LEGS;
  localparam int COST_AW    = $clog2(COST_DEPTH);
  localparam int CMP_W      = ((CNT_W > NIGHTS_W) ? CNT_W : NIGHTS_W) + 1;
  localparam int TDATA_W    = ((SUM_W + 7) / 8) * 8;

  // Cost of a position from which the remaining stops cannot be placed.
  localparam logic [COST_W-1:0] COST_INF = '1;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic               pfx_wr;
    logic               first;
    logic [IDX_W-1:0]   pfx_wr_addr;
    logic               pfx_rd;
    logic [IDX_W-1:0]   pfx_rd_addr;
    logic               cost_rd;
    logic [COST_AW-1:0] cost_rd_addr;
    logic               cost_wr;
    logic [COST_AW-1:0] cost_wr_addr;
    logic               cost_wr_best;
    logic               init_zero;
    logic               base_load;
    logic               base_zero;
    logic               best_init;
    logic               acc;
    logic               out_load;
    logic               out_infeasible;
  } mlp_cmd_t;

  // Address of entry idx in one of the two working rows.
  function automatic logic [COST_AW-1:0] cost_addr(input logic half,
                                                   input logic [IDX_W-1:0] idx);
    logic [COST_AW-1:0] base;
    base = half ? COST_AW'(MAX_LEGS) : '0;
    return base + COST_AW'(idx);
  endfunction

endpackage

`default_nettype wire

// ===== design/mlp_datapath.sv =====
// Datapath: prefix-sum store, two cost rows, running minimum and result register.
`default_nettype none

module mlp_datapath
  import mlp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire mlp_cmd_t            cmd_i,
  input  wire logic [LEG_BITS-1:0] leg_i,
  output logic      [SUM_W-1:0]    stretch_o,
  output logic                     infeasible_o
);

  logic [SUM_W-1:0]  pfx_mem [MAX_LEGS];
  logic [COST_W-1:0] cost_mem [COST_DEPTH];

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [SUM_W-1:0]  pd_q;
  logic [COST_W-1:0] cq_q;
  logic [SUM_W-1:0]  base_q;
  logic [COST_W-1:0] best_q;
  logic              acc_q;
  logic [SUM_W-1:0]  stretch_q;
  logic              infeasible_q;

  logic [SUM_W-1:0]  here;
  logic [COST_W-1:0] worst;
  logic [COST_W-1:0] cost_wdata;
  logic [SUM_W-1:0]  init_sub;

  // Running sum of the legs; the first leg of a data set starts from zero.
  assign sum_d = (cmd_i.first ? '0 : sum_q) + SUM_W'(leg_i);

  // Row zero holds the distance to the end; later rows take the running minimum.
  assign init_sub   = cmd_i.init_zero ? '0 : pd_q;
  assign cost_wdata = cmd_i.cost_wr_best ? best_q : COST_W'(sum_q - init_sub);

  // Worst stretch when the next stop is at the position just read.
  assign here  = pd_q - base_q;
  assign worst = (COST_W'(here) > cq_q) ? COST_W'(here) : cq_q;

  // Memories with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pfx_wr) begin
      pfx_mem[cmd_i.pfx_wr_addr] <= sum_d;
    end
    if (cmd_i.pfx_rd) begin
      pd_q <= pfx_mem[cmd_i.pfx_rd_addr];
    end
    if (cmd_i.cost_wr) begin
      cost_mem[cmd_i.cost_wr_addr] <= cost_wdata;
    end
    if (cmd_i.cost_rd) begin
      cq_q <= cost_mem[cmd_i.cost_rd_addr];
    end
  end

  // Control flops: running sum and the delayed compare enable.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      acc_q <= 1'b0;
    end else begin
      acc_q <= cmd_i.acc;
      if (cmd_i.pfx_wr) begin
        sum_q <= sum_d;
      end
    end
  end

  // Base of the current position, running minimum and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.base_load) begin
      base_q <= cmd_i.base_zero ? '0 : pd_q;
    end
    if (cmd_i.best_init) begin
      best_q <= COST_INF;
    end else if (acc_q && (worst < best_q)) begin
      best_q <= worst;
    end
    if (cmd_i.out_load) begin
      stretch_q    <= cmd_i.out_infeasible ? '0 : cq_q[SUM_W-1:0];
      infeasible_q <= cmd_i.out_infeasible;
    end
  end

  assign stretch_o    = stretch_q;
  assign infeasible_o = infeasible_q;

endmodule

`default_nettype wire

// ===== design/mlp_ctrl.sv =====
// Sequencer: leg intake, solver loop counters, nights register and result handshake.
`default_nettype none

module mlp_ctrl
  import mlp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_valid_i,
  input  wire logic [NIGHTS_W-1:0] cfg_data_i,
  input  wire logic                in_valid_i,
  input  wire logic                in_last_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output mlp_cmd_t                 cmd_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_INIT_RD = 4'd1;
  localparam logic [3:0] ST_INIT_WR = 4'd2;
  localparam logic [3:0] ST_P_BASE  = 4'd3;
  localparam logic [3:0] ST_P_LATCH = 4'd4;
  localparam logic [3:0] ST_INNER   = 4'd5;
  localparam logic [3:0] ST_DRAIN   = 4'd6;
  localparam logic [3:0] ST_P_WRITE = 4'd7;
  localparam logic [3:0] ST_FIN_RD  = 4'd8;
  localparam logic [3:0] ST_DONE    = 4'd9;

  logic [3:0]          state_q, state_d;
  logic [NIGHTS_W-1:0] nights_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [IDX_W-1:0]    sites_q, sites_d;
  logic [IDX_W-1:0]    p_q, p_d;
  logic [IDX_W-1:0]    i_q, i_d;
  logic [NIGHTS_W-1:0] j_q, j_d;
  logic                row_q, row_d;
  logic                infeas_q, infeas_d;
  logic                valid_q, valid_d;

  logic                room;
  logic [CNT_W-1:0]    new_count;
  logic [IDX_W-1:0]    new_sites;
  logic                too_many;

  // Intake bookkeeping for the current leg.
  assign room      = (count_q < CNT_W'(MAX_LEGS));
  assign new_count = room ? count_q + CNT_W'(1) : count_q;
  assign new_sites = IDX_W'(new_count - CNT_W'(1));
  assign too_many  = (CMP_W'(nights_q) > CMP_W'(MAX_NIGHTS)) ||
                     (CMP_W'(nights_q) > CMP_W'(new_sites));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;

  // Next state and datapath commands.
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    sites_d  = sites_q;
    p_d      = p_q;
    i_d      = i_q;
    j_d      = j_q;
    row_d    = row_q;
    infeas_d = infeas_q;
    valid_d  = valid_q;
    cmd_o    = '0;

    if (valid_q && out_ready_i) begin
      valid_d = 1'b0;
    end

    cmd_o.pfx_wr_addr = count_q[IDX_W-1:0];
    cmd_o.first       = (count_q == '0);

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.pfx_wr = room;
          count_d      = new_count;
          if (in_last_i) begin
            count_d  = '0;
            sites_d  = new_sites;
            p_d      = '0;
            row_d    = 1'b0;
            infeas_d = too_many;
            state_d  = too_many ? ST_DONE : ST_INIT_RD;
          end
        end
      end
      ST_INIT_RD: begin
        // Position zero has an empty prefix, so nothing is read for it.
        cmd_o.pfx_rd      = (p_q != '0);
        cmd_o.pfx_rd_addr = p_q - IDX_W'(1);
        state_d           = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        cmd_o.cost_wr      = 1'b1;
        cmd_o.cost_wr_addr = cost_addr(row_q, p_q);
        cmd_o.init_zero    = (p_q == '0);
        if (p_q == sites_q) begin
          p_d = '0;
          if (nights_q == '0) begin
            state_d = ST_FIN_RD;
          end else begin
            j_d     = NIGHTS_W'(1);
            row_d   = ~row_q;
            state_d = ST_P_BASE;
          end
        end else begin
          p_d     = p_q + IDX_W'(1);
          state_d = ST_INIT_RD;
        end
      end
      ST_P_BASE: begin
        cmd_o.pfx_rd      = (p_q != '0);
        cmd_o.pfx_rd_addr = p_q - IDX_W'(1);
        cmd_o.best_init   = 1'b1;
        i_d               = p_q + IDX_W'(1);
        state_d           = ST_P_LATCH;
      end
      ST_P_LATCH: begin
        cmd_o.base_load = 1'b1;
        cmd_o.base_zero = (p_q == '0);
        state_d         = (p_q == sites_q) ? ST_P_WRITE : ST_INNER;
      end
      ST_INNER: begin
        // One candidate stop per cycle; the compare follows in the next cycle.
        cmd_o.pfx_rd       = 1'b1;
        cmd_o.pfx_rd_addr  = i_q - IDX_W'(1);
        cmd_o.cost_rd      = 1'b1;
        cmd_o.cost_rd_addr = cost_addr(~row_q, i_q);
        cmd_o.acc          = 1'b1;
        if (i_q == sites_q) begin
          state_d = ST_DRAIN;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_P_WRITE;
      end
      ST_P_WRITE: begin
        cmd_o.cost_wr      = 1'b1;
        cmd_o.cost_wr_addr = cost_addr(row_q, p_q);
        cmd_o.cost_wr_best = 1'b1;
        if (p_q == sites_q) begin
          p_d = '0;
          if (j_q == nights_q) begin
            state_d = ST_FIN_RD;
          end else begin
            j_d     = j_q + NIGHTS_W'(1);
            row_d   = ~row_q;
            state_d = ST_P_BASE;
          end
        end else begin
          p_d     = p_q + IDX_W'(1);
          state_d = ST_P_BASE;
        end
      end
      ST_FIN_RD: begin
        cmd_o.cost_rd      = 1'b1;
        cmd_o.cost_rd_addr = cost_addr(row_q, '0);
        state_d            = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the result register is free.
        if (!valid_q || out_ready_i) begin
          cmd_o.out_load       = 1'b1;
          cmd_o.out_infeasible = infeas_q;
          valid_d              = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      nights_q <= '0;
      count_q  <= '0;
      sites_q  <= '0;
      p_q      <= '0;
      i_q      <= '0;
      j_q      <= '0;
      row_q    <= 1'b0;
      infeas_q <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      sites_q  <= sites_d;
      p_q      <= p_d;
      i_q      <= i_d;
      j_q      <= j_d;
      row_q    <= row_d;
      infeas_q <= infeas_d;
      valid_q  <= valid_d;
      if (cfg_valid_i) begin
        nights_q <= cfg_data_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/minimax_linear_partition_unit.sv =====
// Top level of the minimax linear partition unit: sequencer plus datapath.
//
//   channel   direction  handshake                      payload
//   s_axis    in         s_axis_tvalid / s_axis_tready  tdata: leg_length; tlast: last_leg
//   m_axis    out        m_axis_tvalid / m_axis_tready  tdata: longest_stretch; tuser: infeasible
//   cfg       in         cfg_valid_i / cfg_ready_o      cfg_data_i: nights
//
// Legs are taken while the sequencer is idle. After the last leg, for S inner
// campsites, the solver writes the first row, then for each night scans, for every
// position p, the candidate stops, one candidate stop per cycle, and writes the best
// cost; it then reads out the answer. An infeasible set skips the solver entirely.
// Input is held off while the solver runs and while a new answer waits for the
// previous one to be taken. Reset clears leg count, nights and handshake state.
`default_nettype none

module minimax_linear_partition_unit
  import mlp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Bits 15:0 leg_length.
  input  wire logic [15:0]         s_axis_tdata,
  input  wire logic                s_axis_tlast,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // Bits 25:0 longest_stretch, upper bits zero.
  output logic [TDATA_W-1:0]       m_axis_tdata,
  // Bit 0 infeasible.
  output logic                     m_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [NIGHTS_W-1:0] cfg_data_i
);

  mlp_cmd_t         cmd;
  logic [SUM_W-1:0] stretch;

  assign cfg_ready_o = 1'b1;

  mlp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  mlp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .leg_i        (s_axis_tdata[LEG_BITS-1:0]),
    .stretch_o    (stretch),
    .infeasible_o (m_axis_tuser)
  );

  assign m_axis_tdata = TDATA_W'(stretch);

endmodule

`default_nettype wire
